// ----- rtl/core/tirp_pkg.sv -----
// ----------------------------------------------------------------------------
// tirp_pkg: shared types and constants for the TI-TXT record parser
// Character codes, command classes passed from the front part to the back
// part, token modes and record kinds.
// ----------------------------------------------------------------------------
package tirp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_Q_UP  = 8'h51;
   localparam logic [7:0] CHAR_Q_LO  = 8'h71;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;
   localparam logic [7:0] CHAR_F_UP  = 8'h46;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_F_LO  = 8'h66;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned DIGIT_W = 4;

   // Record kinds
   localparam logic KIND_ADDR = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // Command class decided by the front part
   typedef enum logic [2:0] {
      OP_DIGIT,
      OP_BLANK,
      OP_AT,
      OP_QUIT,
      OP_EOS
   } op_type;

   // Open token mode held by the back part
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_ADDR = 2'd1,
      MODE_DATA = 2'd2
   } mode_type;

   // One classified item
   typedef struct packed {
      op_type              op;
      logic [DIGIT_W-1:0]  digit;
   } cmd_type;

endpackage

// ----- rtl/core/tirp_front.sv -----
// ----------------------------------------------------------------------------
// tirp_front: input item classifier
// Accepts one character or end-of-stream mark per cycle while the queue has room
// and turns it into a command class plus its hex digit value for the command queue.
// ----------------------------------------------------------------------------
module tirp_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic                  req_end_of_stream,
   input  logic                  q_full,
   output logic                  q_push,
   output tirp_pkg::cmd_type     q_cmd
);
   import tirp_pkg::*;

   logic is_blank;
   logic is_dec;
   logic is_hex_up;
   logic is_hex_lo;

   // Accept whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Decode character classes
   assign is_blank  = (req_char_code == CHAR_SPACE) ||
                      ((req_char_code >= CHAR_TAB) && (req_char_code <= CHAR_CR));
   assign is_dec    = (req_char_code >= CHAR_0) && (req_char_code <= CHAR_9);
   assign is_hex_up = (req_char_code >= CHAR_A_UP) && (req_char_code <= CHAR_F_UP);
   assign is_hex_lo = (req_char_code >= CHAR_A_LO) && (req_char_code <= CHAR_F_LO);

   // Pick the command class and digit value; non-hex counts as zero
   always_comb begin
      q_cmd.digit = '0;
      if (is_dec) begin
         q_cmd.digit = req_char_code[3:0];
      end else if (is_hex_up || is_hex_lo) begin
         q_cmd.digit = HEX_TEN + {1'b0, req_char_code[2:0]} - 4'd1;
      end
      if (req_end_of_stream) begin
         q_cmd.op = OP_EOS;
      end else if (is_blank) begin
         q_cmd.op = OP_BLANK;
      end else if (req_char_code == CHAR_AT) begin
         q_cmd.op = OP_AT;
      end else if ((req_char_code == CHAR_Q_UP) || (req_char_code == CHAR_Q_LO)) begin
         q_cmd.op = OP_QUIT;
      end else begin
         q_cmd.op = OP_DIGIT;
      end
   end

endmodule

// ----- rtl/core/tirp_queue.sv -----
// ----------------------------------------------------------------------------
// tirp_queue: two-entry command queue
// Decouples the classifier from the record builder; push and pop may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module tirp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tirp_pkg::cmd_type     push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output tirp_pkg::cmd_type     head_cmd
);
   import tirp_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/tirp_back.sv -----
// ----------------------------------------------------------------------------
// tirp_back: record builder
// Pops classified items, tracks the open token and its value, and emits a
// record into the output register when a token closes.
// ----------------------------------------------------------------------------
module tirp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  tirp_pkg::cmd_type             q_cmd,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_record_kind,
   output logic [tirp_pkg::VALUE_W-1:0]  rsp_record_value
);
   import tirp_pkg::*;

   mode_type            mode_ff,  mode_in;
   logic [VALUE_W-1:0]  acc_ff,   acc_in;
   logic                stop_ff,  stop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                kind_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic                emit;
   logic                emit_kind;

   // Pop when the output slot is free or drains this cycle
   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   // Next token state and record decision
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      stop_in   = stop_ff;
      emit      = 1'b0;
      emit_kind = (mode_ff == MODE_ADDR) ? KIND_ADDR : KIND_DATA;
      if (q_pop && !stop_ff) begin
         case (q_cmd.op)
            OP_EOS: begin
               emit    = (mode_ff != MODE_IDLE);
               mode_in = MODE_IDLE;
               acc_in  = '0;
               stop_in = 1'b1;
            end
            OP_BLANK: begin
               emit    = (mode_ff != MODE_IDLE);
               mode_in = MODE_IDLE;
               acc_in  = '0;
            end
            default: begin
               if (mode_ff == MODE_IDLE) begin
                  if (q_cmd.op == OP_AT) begin
                     mode_in = MODE_ADDR;
                     acc_in  = '0;
                  end else if (q_cmd.op == OP_QUIT) begin
                     stop_in = 1'b1;
                  end else begin
                     mode_in = MODE_DATA;
                     acc_in  = {{(VALUE_W-DIGIT_W){1'b0}}, q_cmd.digit};
                  end
               end else begin
                  acc_in = {acc_ff[VALUE_W-DIGIT_W-1:0], DIGIT_W'(0)} +
                           {{(VALUE_W-DIGIT_W){1'b0}}, q_cmd.digit};
               end
            end
         endcase
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         acc_ff       <= '0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load record payload
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= emit_kind;
         value_ff <= acc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_kind  = kind_ff;
   assign rsp_record_value = value_ff;

`ifndef SYNTHESIS
   a_no_emit_stopped: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> !emit)
      else $error("record emitted after stop");
   a_emit_needs_token: assert property (@(posedge clock) disable iff (reset)
      emit |-> (mode_ff != MODE_IDLE))
      else $error("record emitted with no open token");
   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff)
      else $error("stop flag cleared without reset");
   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !q_pop)
      else $error("item popped while record stalled");
`endif

endmodule

// ----- rtl/core/ti_txt_record_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ti_txt_record_parser_unit: TI-TXT firmware text record parser
// Parses a character stream into address and data records.
//
//   Channel | Direction | Payload
//   req_    | in        | char_code[7:0], end_of_stream
//   rsp_    | out       | record_kind, record_value[31:0]
//
// One item per cycle sustained while rsp_ does not stall. A record appears on
// rsp_ after the item that closes its token is accepted and passes through the
// command queue, then the output register.
// Synchronous reset clears the queue, token state, stop flag and output valid.
// A stalled rsp_ holds the builder; req_ keeps taking items until the
// two-entry queue fills.
// ----------------------------------------------------------------------------
module ti_txt_record_parser_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_code,
   input  logic                          req_end_of_stream,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_record_kind,
   output logic [tirp_pkg::VALUE_W-1:0]  rsp_record_value
);
   import tirp_pkg::*;

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // Classify input items
   tirp_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   // Buffer classified items
   tirp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // Build and emit records
   tirp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_record_value (rsp_record_value)
   );

endmodule
